[rtl/afk_pkg.sv]
// package for the arm forward kinematics block: widths, cordic constants, helpers
package afk_pkg;

    localparam int CordicSteps = 14;
    localparam int TableLen    = 24;
    localparam int NumSteps    = (CordicSteps < TableLen) ? CordicSteps : TableLen;

    // cordic datapath and angle width (2^-30 rad units, |a| < 16 rad)
    localparam int CW = 34;
    localparam int AW = 35;

    localparam logic signed [AW-1:0] AngPi     = 35'sd3373259426;
    localparam logic signed [AW-1:0] AngTwoPi  = 35'sd6746518852;
    localparam logic signed [AW-1:0] AngHalfPi = 35'sd1686629713;
    localparam logic signed [CW-1:0] GainQ30   = 34'sd652032874;

    typedef enum logic [1:0] {
        CFG_BASE_HEIGHT = 2'd0,
        CFG_UPPER_LINK  = 2'd1,
        CFG_WRIST       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] rot_xx;
        logic signed [15:0] rot_xy;
        logic signed [15:0] rot_xz;
        logic signed [15:0] rot_yx;
        logic signed [15:0] rot_yy;
        logic signed [15:0] rot_yz;
        logic signed [15:0] rot_zx;
        logic signed [15:0] rot_zz;
        logic signed [18:0] pos_x;
        logic signed [18:0] pos_y;
        logic signed [18:0] pos_z;
    } afk_result_t;

    // truncated atan(2^-i) table in 2^-30 rad
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] v;
        begin
            case (i)
                0: v = 35'sd843314856;
                1: v = 35'sd497837829;
                2: v = 35'sd263043836;
                3: v = 35'sd133525158;
                4: v = 35'sd67021686;
                5: v = 35'sd33543515;
                6: v = 35'sd16775850;
                7: v = 35'sd8388437;
                8: v = 35'sd4194282;
                9: v = 35'sd2097149;
                10: v = 35'sd1048575;
                11: v = 35'sd524287;
                12: v = 35'sd262143;
                13: v = 35'sd131071;
                14: v = 35'sd65535;
                15: v = 35'sd32767;
                16: v = 35'sd16383;
                17: v = 35'sd8191;
                18: v = 35'sd4095;
                19: v = 35'sd2047;
                20: v = 35'sd1023;
                21: v = 35'sd511;
                22: v = 35'sd255;
                23: v = 35'sd127;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // round a Q2.30 value to Q1.14 and clamp
    function automatic logic signed [15:0] rot_single(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        begin
            r = (v + (CW+1)'(32768)) >>> 16;
            if (r > 16384) return 16'sd16384;
            else if (r < -16384) return -16'sd16384;
            else return r[15:0];
        end
    endfunction

    // round a Q4.60 product to Q1.14 and clamp
    function automatic logic signed [15:0] rot_prod(input logic signed [67:0] p);
        logic signed [67:0] r;
        begin
            r = (p + (68'sd1 <<< 45)) >>> 46;
            if (r > 16384) return 16'sd16384;
            else if (r < -16384) return -16'sd16384;
            else return r[15:0];
        end
    endfunction

    // saturate to 19-bit signed
    function automatic logic signed [18:0] sat19(input logic signed [63:0] v);
        begin
            if (v > 64'sd262143) return 19'sd262143;
            else if (v < -64'sd262144) return -19'sd262144;
            else return v[18:0];
        end
    endfunction

endpackage

[rtl/afk_cordic.sv]
// pipelined rotation-mode cordic with angle wrap and fold; one stage per step
module afk_cordic (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [afk_pkg::AW-1:0] angle,
    output logic signed [afk_pkg::CW-1:0] sin_out,
    output logic signed [afk_pkg::CW-1:0] cos_out
);
    import afk_pkg::*;

    logic signed [AW-1:0] a_reg [NumSteps+1];
    logic signed [CW-1:0] x_reg [NumSteps+1];
    logic signed [CW-1:0] y_reg [NumSteps+1];
    logic                 f_reg [NumSteps+1];

    logic signed [AW-1:0] w_next;
    logic signed [AW-1:0] a_next;
    logic                 f_next;

    // wrap into [-pi, pi], fold into [-pi/2, pi/2]
    always_comb begin
        w_next = angle;
        if (angle > AngPi) w_next = angle - AngTwoPi;
        else if (angle < -AngPi) w_next = angle + AngTwoPi;
        a_next = w_next;
        f_next = 1'b0;
        if (w_next > AngHalfPi) begin
            a_next = w_next - AngPi;
            f_next = 1'b1;
        end else if (w_next < -AngHalfPi) begin
            a_next = w_next + AngPi;
            f_next = 1'b1;
        end
    end

    // front stage
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg[0] <= a_next;
            x_reg[0] <= GainQ30;
            y_reg[0] <= '0;
            f_reg[0] <= f_next;
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < NumSteps; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                f_reg[i+1] <= f_reg[i];
                if (!a_reg[i][AW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_tab(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_tab(i);
                end
            end
        end
    end

    assign sin_out = f_reg[NumSteps] ? -y_reg[NumSteps] : y_reg[NumSteps];
    assign cos_out = f_reg[NumSteps] ? -x_reg[NumSteps] : x_reg[NumSteps];

endmodule

[rtl/afk_compose.sv]
// three-stage back end: products, radial/z sums, rounding and saturation
module afk_compose (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [afk_pkg::CW-1:0] s1,
    input  logic signed [afk_pkg::CW-1:0] c1,
    input  logic signed [afk_pkg::CW-1:0] s2,
    input  logic signed [afk_pkg::CW-1:0] c2,
    input  logic signed [afk_pkg::CW-1:0] s23,
    input  logic signed [afk_pkg::CW-1:0] c23,
    input  logic [15:0]                   d1,
    input  logic [15:0]                   a2,
    input  logic [15:0]                   d4,
    output afk_pkg::afk_result_t          res
);
    import afk_pkg::*;

    // stage 1: rotation entries and link products
    logic signed [15:0] rxx_reg, rxy_reg, rxz_reg, ryx_reg, ryy_reg, ryz_reg, rzx_reg, rzz_reg;
    logic signed [CW-1:0] s1_reg, c1_reg;
    logic signed [51:0] a2c2_reg, d4s23_reg, a2s2_reg, d4c23_reg;
    logic [15:0] d1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rxx_reg   <= rot_prod(68'(c1) * 68'(c23));
            rxy_reg   <= rot_single(-(CW+1)'(s1));
            rxz_reg   <= rot_prod(68'(c1) * 68'(s23));
            ryx_reg   <= rot_prod(68'(s1) * 68'(c23));
            ryy_reg   <= rot_single((CW+1)'(c1));
            ryz_reg   <= rot_prod(68'(s1) * 68'(s23));
            rzx_reg   <= rot_single(-(CW+1)'(s23));
            rzz_reg   <= rot_single((CW+1)'(c23));
            a2c2_reg  <= 52'($signed({1'b0, a2})) * 52'(c2);
            d4s23_reg <= 52'($signed({1'b0, d4})) * 52'(s23);
            a2s2_reg  <= 52'($signed({1'b0, a2})) * 52'(s2);
            d4c23_reg <= 52'($signed({1'b0, d4})) * 52'(c23);
            s1_reg    <= s1;
            c1_reg    <= c1;
            d1_reg    <= d1;
        end
    end

    // stage 2: radial term rounded to 2^-12, z rounded to an integer and saturated
    logic signed [15:0] rxx2_reg, rxy2_reg, rxz2_reg, ryx2_reg, ryy2_reg, ryz2_reg, rzx2_reg, rzz2_reg;
    logic signed [CW-1:0] s12_reg, c12_reg;
    logic signed [35:0] rad_reg;
    logic signed [18:0] pz_reg;
    logic signed [53:0] rsum;
    logic signed [53:0] zsum;

    always_comb begin
        rsum = 54'(a2c2_reg) + 54'(d4s23_reg) + 54'sd131072;
        zsum = $signed({2'b0, d1_reg, 30'd0}) + 54'sd0 - 54'(a2s2_reg) + 54'(d4c23_reg)
               + 54'sd536870912;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            {rxx2_reg, rxy2_reg, rxz2_reg, ryx2_reg} <= {rxx_reg, rxy_reg, rxz_reg, ryx_reg};
            {ryy2_reg, ryz2_reg, rzx2_reg, rzz2_reg} <= {ryy_reg, ryz_reg, rzx_reg, rzz_reg};
            s12_reg <= s1_reg;
            c12_reg <= c1_reg;
            rad_reg <= 36'(rsum >>> 18);
            pz_reg  <= sat19(64'(zsum >>> 30));
        end
    end

    // stage 3: x and y products, rounding and saturation
    afk_result_t res_reg;
    logic signed [69:0] px, py;

    always_comb begin
        px = 70'(c12_reg) * 70'(rad_reg) + (70'sd1 <<< 41);
        py = 70'(s12_reg) * 70'(rad_reg) + (70'sd1 <<< 41);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.rot_xx <= rxx2_reg;
            res_reg.rot_xy <= rxy2_reg;
            res_reg.rot_xz <= rxz2_reg;
            res_reg.rot_yx <= ryx2_reg;
            res_reg.rot_yy <= ryy2_reg;
            res_reg.rot_yz <= ryz2_reg;
            res_reg.rot_zx <= rzx2_reg;
            res_reg.rot_zz <= rzz2_reg;
            res_reg.pos_x  <= sat19(64'(px >>> 42));
            res_reg.pos_y  <= sat19(64'(py >>> 42));
            res_reg.pos_z  <= pz_reg;
        end
    end

    assign res = res_reg;

endmodule

[rtl/arm_forward_kinematics_3dof.sv]
// throughput: one word per cycle; the whole pipeline advances together, held by m_tready
// depth: one wrap stage, one micro-rotation per cordic stage, plus three output stages
// reset: aresetn synchronous active low clears the valid bits and loads register defaults
// link registers reset to base_height 2048, upper_link_length 1638, wrist_offset 1024
module arm_forward_kinematics_3dof (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // joint_one_angle[15:0], joint_two_angle[31:16], joint_three_angle[47:32]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx, rot_zz (16 each),
    // pos_x, pos_y, pos_z (19 each), from bit 0 up, zero filled to 192
    output logic [191:0] m_tdata
);
    import afk_pkg::*;

    localparam int Lat = NumSteps + 4;

    logic [15:0] d1_reg, a2_reg, d4_reg;
    logic [Lat-1:0] vld_reg;
    logic en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_reg <= 16'd2048;
            a2_reg <= 16'd1638;
            d4_reg <= 16'd1024;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_BASE_HEIGHT: d1_reg <= cfg_wdata;
                CFG_UPPER_LINK:  a2_reg <= cfg_wdata;
                CFG_WRIST:       d4_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advances unless the output word is stalled
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Lat-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Lat-2:0], s_tvalid};
    end

    // angle scaling to 2^-30 rad
    logic signed [15:0] q1, q2, q3;
    logic signed [AW-1:0] ang1, ang2, ang23;
    assign q1 = s_tdata[15:0];
    assign q2 = s_tdata[31:16];
    assign q3 = s_tdata[47:32];
    assign ang1  = AW'(q1) <<< 17;
    assign ang2  = AW'(q2) <<< 17;
    assign ang23 = (AW'(q2) + AW'(q3)) <<< 17;

    logic signed [CW-1:0] s1, c1, s2, c2, s23, c23;

    afk_cordic u_cordic1 (.aclk(aclk), .en(en), .angle(ang1), .sin_out(s1), .cos_out(c1));
    afk_cordic u_cordic2 (.aclk(aclk), .en(en), .angle(ang2), .sin_out(s2), .cos_out(c2));
    afk_cordic u_cordic3 (.aclk(aclk), .en(en), .angle(ang23), .sin_out(s23), .cos_out(c23));

    afk_result_t res;

    afk_compose u_compose (
        .aclk(aclk), .en(en),
        .s1(s1), .c1(c1), .s2(s2), .c2(c2), .s23(s23), .c23(c23),
        .d1(d1_reg), .a2(a2_reg), .d4(d4_reg),
        .res(res)
    );

    assign m_tdata = {7'd0, res.pos_z, res.pos_y, res.pos_x,
                      res.rot_zz, res.rot_zx, res.rot_yz, res.rot_yy,
                      res.rot_yx, res.rot_xz, res.rot_xy, res.rot_xx};

    // stalled output word holds its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed under stall");
    // rot_zz rotation entry stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(res.rot_zz) <= 16384 && $signed(res.rot_zz) >= -16384)
        else $error("rot_zz out of range");
    // input is open whenever no output word waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
endmodule
